/* hw/rtl/ctu_pkg.sv */
// ----------------------------------------------------------------------------
// ctu_pkg - shared types and constants of the columnar transposition unit
// Buffer sizing, field widths, status and register codes, sequencer states.
// ----------------------------------------------------------------------------
package ctu_pkg;

  // Message buffer depth and derived widths
  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int STEP_W  = $clog2(CNT_W + 1);

  // Field widths
  localparam int DATA_W  = 8;
  localparam int COL_W   = 7;
  localparam int STAT_W  = 2;
  localparam int CFG_A_W = 1;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_LEN  = 2'd1,
    STAT_TOO_LONG = 2'd2
  } status_t;

  // Register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_COLUMN_COUNT = 1'b0,
    CFG_DIRECTION    = 1'b1
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SEND,
    ST_ERR
  } ctu_state_t;

  // Divider result bundle
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quot;
    logic [COL_W-1:0] rem;
  } div_res_t;

endpackage

/* hw/rtl/ctu_div.sv */
// ----------------------------------------------------------------------------
// ctu_div - iterative restoring divider
// Divides the message length by the column count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ctu_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [ctu_pkg::CNT_W-1:0] dividend,
  input  logic [ctu_pkg::COL_W-1:0] divisor,
  output ctu_pkg::div_res_t       res
);
  import ctu_pkg::*;

  logic [COL_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  quo_r, quo_nxt;
  logic [COL_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [COL_W:0]    trial;
  logic [COL_W:0]    diff;

  // One shift-subtract step per cycle
  always_comb begin
    trial    = {rem_r, quo_r[CNT_W-1]};
    diff     = trial - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      step_nxt = STEP_W'(CNT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[COL_W-1:0];
        quo_nxt = {quo_r[CNT_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[COL_W-1:0];
        quo_nxt = {quo_r[CNT_W-2:0], 1'b0};
      end
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

endmodule

/* hw/rtl/ctu_buf.sv */
// ----------------------------------------------------------------------------
// ctu_buf - message buffer
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module ctu_buf (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ctu_pkg::ADDR_W-1:0] wr_addr,
  input  logic [ctu_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ctu_pkg::ADDR_W-1:0] rd_addr,
  output logic [ctu_pkg::DATA_W-1:0] rd_data
);
  import ctu_pkg::*;

  logic [DATA_W-1:0] mem [MAX_LEN];
  logic [DATA_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/columnar_transposition_unit.sv */
// ----------------------------------------------------------------------------
// columnar_transposition_unit - columnar transposition cipher
// Buffers a message, then reads it back column by column of its grid.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | slave     | tvalid/tready      | tdata: data_byte; tlast: last_byte
//  out_    | master    | tvalid/tready      | tdata: out_byte; tlast: end; tuser: status
//  cfg_    | slave     | we (no wait)       | addr: register index; wdata: value
//
//  Each input byte takes one cycle. The byte with tlast starts a length
//  check in the divider, which forms the quotient bit by bit before the
//  sequencer acts on the result. A clean message then gives its results
//  one at a time, each a buffer read followed by a send state. Overflow
//  or zero columns give the error result on the next cycle; a ragged
//  length gives it once the length check is done.
//  in_tready is low from the last byte until the last result is taken;
//  out_tready low simply holds the current result.
//  Synchronous reset clears the sequencer, byte count and overflow flag and
//  sets column_count 1, encrypt. The buffer itself is not cleared.
// ----------------------------------------------------------------------------
module columnar_transposition_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ctu_pkg::DATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                        in_tlast,
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ctu_pkg::DATA_W-1:0]  out_tdata,  // [7:0] out_byte
  output logic                        out_tlast,
  output logic [ctu_pkg::STAT_W-1:0]  out_tuser,  // [1:0] status
  // configuration
  input  logic                        cfg_we,
  input  logic [ctu_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [ctu_pkg::COL_W-1:0]   cfg_wdata
);
  import ctu_pkg::*;

  ctu_state_t       state_r, state_nxt;
  logic [COL_W-1:0] column_count_r;
  logic             direction_r;
  logic [CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] width_r, width_nxt;
  logic [CNT_W-1:0] height_r, height_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  status_t          status_r, status_nxt;

  logic             full;
  logic             is_last_res;
  logic             div_start;
  logic             wr_en;
  logic             rd_en;
  logic [DATA_W-1:0] rd_data;
  div_res_t         div_res;

  assign full        = (byte_cnt_r == MAX_CNT);
  assign is_last_res = ((k_r + CNT_W'(1)) == len_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= COL_W'(1);
      direction_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_COLUMN_COUNT: column_count_r <= cfg_wdata;
        CFG_DIRECTION:    direction_r    <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  // Length divider
  ctu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (byte_cnt_r + CNT_W'(1)),
    .divisor  (column_count_r),
    .res      (div_res)
  );

  // Message buffer
  ctu_buf u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (byte_cnt_r[ADDR_W-1:0]),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (pos_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt    = state_r;
    byte_cnt_nxt = byte_cnt_r;
    ovf_nxt      = ovf_r;
    len_nxt      = len_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    pos_nxt      = pos_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    k_nxt        = k_r;
    status_nxt   = status_r;
    div_start    = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            wr_en        = 1'b1;
            byte_cnt_nxt = byte_cnt_r + CNT_W'(1);
          end
          if (in_tlast) begin
            byte_cnt_nxt = '0;
            ovf_nxt      = 1'b0;
            len_nxt      = full ? byte_cnt_r : byte_cnt_r + CNT_W'(1);
            if (ovf_r || full) begin
              status_nxt = STAT_TOO_LONG;
              state_nxt  = ST_ERR;
            end else if (column_count_r == '0) begin
              status_nxt = STAT_BAD_LEN;
              state_nxt  = ST_ERR;
            end else begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          if (div_res.rem != '0) begin
            status_nxt = STAT_BAD_LEN;
            state_nxt  = ST_ERR;
          end else begin
            // column_count fits CNT_W here: it divides a length <= MAX_LEN
            width_nxt  = direction_r ? div_res.quot : column_count_r[CNT_W-1:0];
            height_nxt = direction_r ? column_count_r[CNT_W-1:0] : div_res.quot;
            pos_nxt    = '0;
            row_nxt    = '0;
            col_nxt    = '0;
            k_nxt      = '0;
            status_nxt = STAT_OK;
            state_nxt  = ST_READ;
          end
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_tready) begin
          if (is_last_res) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + CNT_W'(1);
            state_nxt = ST_READ;
            // walk down the column, then step to the top of the next one
            if ((row_r + CNT_W'(1)) == height_r) begin
              row_nxt = '0;
              col_nxt = col_r + CNT_W'(1);
              pos_nxt = col_r + CNT_W'(1);
            end else begin
              row_nxt = row_r + CNT_W'(1);
              pos_nxt = pos_r + width_r;
            end
          end
        end
      end
      ST_ERR: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      byte_cnt_r <= '0;
      ovf_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // Grid walk registers
  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    width_r  <= width_nxt;
    height_r <= height_nxt;
    pos_r    <= pos_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    k_r      <= k_nxt;
    status_r <= status_nxt;
  end

  // Ports
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_SEND) || (state_r == ST_ERR);
  assign out_tdata  = (state_r == ST_ERR) ? '0 : rd_data;
  assign out_tlast  = (state_r == ST_ERR) || is_last_res;
  assign out_tuser  = status_r;

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input taken while a result is pending");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the length check");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND) |-> (pos_r < len_r))
    else $error("buffer read beyond message length");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= MAX_CNT)
    else $error("byte count beyond buffer depth");

  a_read_then_send: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_SEND))
    else $error("buffer read not followed by a result");

endmodule
